>>> src/l4cu_pkg.sv
// shared types, codes and constants of the translated l4 checksum update core
package l4cu_pkg;

  localparam int ACC_W  = 24;
  localparam int WORD_W = 16;
  localparam int POS_W  = 5;

  // command codes
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_ORIG   = 2'd1;
  localparam logic [1:0] CMD_NEW    = 2'd2;
  localparam logic [1:0] CMD_FINISH = 2'd3;

  // transport protocol numbers
  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

  // ip version nibbles
  localparam logic [3:0] VER_IPV4 = 4'd4;
  localparam logic [3:0] VER_IPV6 = 4'd6;

  // word positions inside the headers
  localparam logic [POS_W-1:0] POS_MAX        = 5'd31;
  localparam logic [POS_W-1:0] V4_POS_LEN     = 5'd1;
  localparam logic [POS_W-1:0] V4_POS_PROTO   = 5'd4;
  localparam logic [POS_W-1:0] V4_POS_ADDR_LO = 5'd6;
  localparam logic [POS_W-1:0] V4_POS_ADDR_HI = 5'd9;
  localparam logic [POS_W-1:0] V6_POS_LEN     = 5'd2;
  localparam logic [POS_W-1:0] V6_POS_NXT     = 5'd3;
  localparam logic [POS_W-1:0] V6_POS_ADDR_LO = 5'd4;
  localparam logic [POS_W-1:0] V6_POS_ADDR_HI = 5'd19;

  localparam logic [WORD_W-1:0] SUM_MASK = 16'hffff;

  typedef struct packed {
    logic clear;
    logic take;
    logic active;
    logic with_len;
  } l4cu_stream_ctrl_t;

endpackage

>>> src/l4cu_if.sv
// valid/ready channel interfaces for the input items and the result items
interface l4cu_in_if import l4cu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [WORD_W-1:0] header_word;
  logic [7:0]        protocol;

  modport source (output valid, cmd, header_word, protocol, input ready);
  modport sink (input valid, cmd, header_word, protocol, output ready);
endinterface

interface l4cu_out_if import l4cu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] new_checksum;
  logic              status;
  logic              bad_version;

  modport source (output valid, new_checksum, status, bad_version, input ready);
  modport sink (input valid, new_checksum, status, bad_version, output ready);
endinterface

>>> src/l4cu_stream.sv
// per-header tracker: word position, version, ihl and pseudo-header weight
module l4cu_stream import l4cu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  l4cu_stream_ctrl_t ctrl,
  input  logic [WORD_W-1:0] word,
  output logic [WORD_W-1:0] weight,
  output logic              ver_bad
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [3:0]       ver_r, ver_nxt;
  logic [3:0]       ihl_r, ihl_nxt;
  logic             use_word;

  assign use_word = ctrl.take && ctrl.active && (pos_r != '0);

  // first word only carries version and ihl
  assign ver_bad = ctrl.take && ctrl.active && (pos_r == '0) &&
                   (word[15:12] != VER_IPV4) && (word[15:12] != VER_IPV6);

  always_comb begin
    weight = '0;
    if (use_word) begin
      unique case (ver_r)
        VER_IPV4: begin
          if (pos_r == V4_POS_LEN) begin
            // total length minus header bytes, wrapped to 16 bits
            if (ctrl.with_len) weight = word - {10'd0, ihl_r, 2'd0};
          end else if (pos_r == V4_POS_PROTO) begin
            weight = {8'd0, word[7:0]};
          end else if (pos_r >= V4_POS_ADDR_LO && pos_r <= V4_POS_ADDR_HI) begin
            weight = word;
          end
        end
        VER_IPV6: begin
          if (pos_r == V6_POS_LEN) begin
            if (ctrl.with_len) weight = word;
          end else if (pos_r == V6_POS_NXT) begin
            weight = {8'd0, word[15:8]};
          end else if (pos_r >= V6_POS_ADDR_LO && pos_r <= V6_POS_ADDR_HI) begin
            weight = word;
          end
        end
        default: weight = '0;
      endcase
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    ver_nxt = ver_r;
    ihl_nxt = ihl_r;
    if (ctrl.clear) begin
      pos_nxt = '0;
      ver_nxt = '0;
      ihl_nxt = '0;
    end else if (ctrl.take) begin
      if (pos_r == '0) begin
        ver_nxt = word[15:12];
        ihl_nxt = word[11:8];
      end
      if (pos_r != POS_MAX) pos_nxt = pos_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ver_r <= '0;
      ihl_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      ver_r <= ver_nxt;
      ihl_r <= ihl_nxt;
    end
  end

endmodule

>>> src/l4cu_fold.sv
// end-around fold of the signed accumulator to a 16-bit one's complement sum
module l4cu_fold import l4cu_pkg::*; (
  input  logic signed [ACC_W-1:0] acc,
  output logic        [WORD_W-1:0] sum
);

  logic signed [17:0] s1;
  logic signed [17:0] s2;

  // high byte is an arithmetic shift, low half is the two's complement low bits
  assign s1 = $signed({{10{acc[ACC_W-1]}}, acc[ACC_W-1:16]}) +
              $signed({2'b00, acc[15:0]});

  // a second pass can only borrow or carry once
  always_comb begin
    if (s1[17]) begin
      s2 = s1 + 18'sd65535;
    end else if (s1[16]) begin
      s2 = s1 - 18'sd65535;
    end else begin
      s2 = s1;
    end
  end

  assign sum = s2[WORD_W-1:0];

endmodule

>>> src/translated_l4_checksum_update_core.sv
// a finish transfer passes the input register, then the result register, before its result shows on out_ch
// throughput: one item per cycle, every command, except while a finish stalls; a header word costs one accumulator add
// a finish stalls only while the output register holds an untaken result
// reset (rst_n low, synchronous) clears the accumulator, protocol, header trackers and flags
// the output register is empty after reset and no result is pending
module translated_l4_checksum_update_core import l4cu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  l4cu_in_if.sink    in_ch,
  l4cu_out_if.source out_ch
);

  // input register
  logic              s0_valid_r, s0_valid_nxt;
  logic [1:0]        s0_cmd_r;
  logic [WORD_W-1:0] s0_word_r;
  logic [7:0]        s0_proto_r;
  logic              s0_go;
  logic              in_xfer;

  // block state
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0]       old_r, old_nxt;
  logic [7:0]              proto_r, proto_nxt;
  logic                    verr_r, verr_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_sum_r;
  logic              out_status_r;
  logic              out_bad_r;

  logic              do_start, do_orig, do_new, do_finish;
  logic              orig_active, new_active, with_len;
  l4cu_stream_ctrl_t orig_ctrl, new_ctrl;
  logic [WORD_W-1:0] orig_weight, new_weight;
  logic              orig_ver_bad, new_ver_bad;
  logic [WORD_W-1:0] folded;

  assign s0_go   = s0_valid_r &&
                   ((s0_cmd_r != CMD_FINISH) || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s0_valid_r || s0_go;
  assign in_xfer = in_ch.valid && in_ch.ready;

  assign do_start  = s0_go && (s0_cmd_r == CMD_START);
  assign do_orig   = s0_go && (s0_cmd_r == CMD_ORIG);
  assign do_new    = s0_go && (s0_cmd_r == CMD_NEW);
  assign do_finish = s0_go && (s0_cmd_r == CMD_FINISH);

  always_comb begin
    orig_active = 1'b0;
    new_active  = 1'b0;
    with_len    = 1'b0;
    unique case (proto_r) inside
      PROTO_TCP, PROTO_UDP: begin
        orig_active = 1'b1;
        new_active  = 1'b1;
      end
      PROTO_ICMP: begin
        orig_active = 1'b1;
        with_len    = 1'b1;
      end
      PROTO_ICMPV6: begin
        new_active = 1'b1;
        with_len   = 1'b1;
      end
      default: begin
        orig_active = 1'b0;
      end
    endcase
  end

  always_comb begin
    orig_ctrl.clear    = do_start;
    orig_ctrl.take     = do_orig;
    orig_ctrl.active   = orig_active;
    orig_ctrl.with_len = with_len;
    new_ctrl.clear     = do_start;
    new_ctrl.take      = do_new;
    new_ctrl.active    = new_active;
    new_ctrl.with_len  = with_len;
  end

  l4cu_stream u_orig (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (orig_ctrl),
    .word    (s0_word_r),
    .weight  (orig_weight),
    .ver_bad (orig_ver_bad)
  );

  l4cu_stream u_new (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (new_ctrl),
    .word    (s0_word_r),
    .weight  (new_weight),
    .ver_bad (new_ver_bad)
  );

  l4cu_fold u_fold (
    .acc (acc_r),
    .sum (folded)
  );

  always_comb begin
    acc_nxt   = acc_r;
    old_nxt   = old_r;
    proto_nxt = proto_r;
    verr_nxt  = verr_r;
    if (do_start) begin
      old_nxt   = s0_word_r;
      proto_nxt = s0_proto_r;
      acc_nxt   = $signed({8'd0, ~s0_word_r & SUM_MASK});
      verr_nxt  = 1'b0;
    end else if (do_orig) begin
      acc_nxt  = acc_r - $signed({8'd0, orig_weight});
      verr_nxt = verr_r | orig_ver_bad;
    end else if (do_new) begin
      acc_nxt  = acc_r + $signed({8'd0, new_weight});
      verr_nxt = verr_r | new_ver_bad;
    end
  end

  always_comb begin
    s0_valid_nxt = s0_valid_r;
    if (in_xfer) begin
      s0_valid_nxt = 1'b1;
    end else if (s0_go) begin
      s0_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (do_finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      old_r       <= '0;
      proto_r     <= '0;
      verr_r      <= 1'b0;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      old_r       <= old_nxt;
      proto_r     <= proto_nxt;
      verr_r      <= verr_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s0_cmd_r   <= in_ch.cmd;
      s0_word_r  <= in_ch.header_word;
      s0_proto_r <= in_ch.protocol;
    end
    if (do_finish) begin
      // unsupported protocol echoes the old checksum
      if (orig_active || new_active) begin
        out_sum_r    <= ~folded;
        out_status_r <= 1'b0;
      end else begin
        out_sum_r    <= old_r;
        out_status_r <= 1'b1;
      end
      out_bad_r <= verr_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.new_checksum = out_sum_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.bad_version  = out_bad_r;

endmodule

>>> src/l4cu_checker.sv
// port-level checks of the checksum update core, bound to the top level
module l4cu_checker import l4cu_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] out_new_checksum,
  input logic              out_status,
  input logic              out_bad_version
);

  // a result held back keeps its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_checksum) &&
                                $stable(out_status) && $stable(out_bad_version))
    else $error("stalled result changed");

  // an unsupported protocol never has a header in use, so no version flag
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_bad_version)
    else $error("version flag on unsupported protocol");

  // the output register is empty after reset
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // input only stalls behind a result that is not taken
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

endmodule

bind translated_l4_checksum_update_core l4cu_checker u_l4cu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_new_checksum (out_ch.new_checksum),
  .out_status       (out_ch.status),
  .out_bad_version  (out_ch.bad_version)
);
